// File: rtl/core/ghbdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ghbdc_pkg;

  // fixed field widths
  localparam int ADDR_W = 64;
  localparam int CFG_W = 4;
  localparam int GEN_W = 2;
  localparam int REG_IDX_W = 2;

  // per-axis limit on chains and deltas, and the result bound that follows
  localparam logic [CFG_W-1:0] AXIS_LIMIT = 4'd8;
  localparam int MAX_RESULTS = 64;
  localparam int SEEN_AW = 6;
  localparam int CNT_W = 7;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_WIDTH = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DEPTH = 2'd1;

  // register reset values
  localparam logic [CFG_W-1:0] WIDTH_RESET = 4'd2;
  localparam logic [CFG_W-1:0] DEPTH_RESET = 4'd4;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_LIVE_RD,
    ST_LIVE_CMP,
    ST_CHAIN,
    ST_DEPTH,
    ST_ADD,
    ST_SEEN_RD,
    ST_SEEN_CMP,
    ST_STORE,
    ST_NEXT,
    ST_LINK,
    ST_LINK_CMP,
    ST_PUSH,
    ST_PREV,
    ST_PREV_KEY,
    ST_ADVANCE,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic take_first;
    logic take_step;
    logic scan_inc;
    logic hit_latch;
    logic walk_start;
    logic chain_start;
    logic delta_rd_prev;
    logic add;
    logic k_inc;
    logic store;
    logic depth_next;
    logic w_inc;
    logic cur_follow;
    logic push;
    logic key_from_delta;
    logic update;
    logic link_set;
    logic insert;
    logic advance;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic prev_valid;
    logic scan_valid;
    logic scan_last;
    logic key_match;
    logic live;
    logic w_more;
    logic d_more;
    logic k_more;
    logic seen_match;
    logic can_store;
    logic link_valid;
    logic link_ok;
    logic prev_dvalid;
    logic pend_valid;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// File: rtl/core/ghbdc_access_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ghbdc_access_if;
  logic                         valid;
  logic                         ready;
  logic [ghbdc_pkg::ADDR_W-1:0] access_address;

  modport source (output valid, output access_address, input ready);
  modport sink (input valid, input access_address, output ready);
endinterface

`default_nettype wire

// File: rtl/core/ghbdc_prefetch_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ghbdc_prefetch_if;
  logic                         valid;
  logic                         ready;
  logic [ghbdc_pkg::ADDR_W-1:0] prefetch_address;
  logic                         last_of_run;

  modport source (output valid, output prefetch_address, output last_of_run, input ready);
  modport sink (input valid, input prefetch_address, input last_of_run, output ready);
endinterface

`default_nettype wire

// File: rtl/core/ghbdc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ghbdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/ghbdc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ghbdc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire ghbdc_pkg::status_t status,
  output ghbdc_pkg::cmd_t         cmd
);

  ghbdc_pkg::state_t state, state_next;
  logic upd_phase, upd_phase_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ghbdc_pkg::ST_IDLE;
      upd_phase <= 1'b0;
    end else begin
      state <= state_next;
      upd_phase <= upd_phase_next;
    end
  end

  // next state and commands
  always_comb begin
    cmd = '0;
    state_next = state;
    upd_phase_next = upd_phase;
    case (state)
      ghbdc_pkg::ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid) begin
          if (!status.prev_valid) begin
            cmd.take_first = 1'b1;
          end else begin
            cmd.take_step = 1'b1;
            upd_phase_next = 1'b0;
            state_next = ghbdc_pkg::ST_SRCH_RD;
          end
        end
      end
      ghbdc_pkg::ST_SRCH_RD: begin
        if (status.scan_valid) begin
          state_next = ghbdc_pkg::ST_SRCH_CMP;
        end else if (upd_phase) begin
          cmd.insert = 1'b1;
          state_next = ghbdc_pkg::ST_ADVANCE;
        end else begin
          state_next = ghbdc_pkg::ST_PUSH;
        end
      end
      ghbdc_pkg::ST_SRCH_CMP: begin
        if (status.key_match) begin
          cmd.hit_latch = 1'b1;
          state_next = ghbdc_pkg::ST_LIVE_RD;
        end else if (!status.scan_last) begin
          cmd.scan_inc = 1'b1;
          state_next = ghbdc_pkg::ST_SRCH_RD;
        end else if (upd_phase) begin
          cmd.insert = 1'b1;
          state_next = ghbdc_pkg::ST_ADVANCE;
        end else begin
          state_next = ghbdc_pkg::ST_PUSH;
        end
      end
      ghbdc_pkg::ST_LIVE_RD: begin
        state_next = ghbdc_pkg::ST_LIVE_CMP;
      end
      ghbdc_pkg::ST_LIVE_CMP: begin
        if (upd_phase) begin
          cmd.update = 1'b1;
          cmd.link_set = status.live;
          state_next = ghbdc_pkg::ST_ADVANCE;
        end else if (status.live) begin
          cmd.walk_start = 1'b1;
          state_next = ghbdc_pkg::ST_CHAIN;
        end else begin
          state_next = ghbdc_pkg::ST_PUSH;
        end
      end
      ghbdc_pkg::ST_CHAIN: begin
        if (status.w_more) begin
          cmd.chain_start = 1'b1;
          state_next = ghbdc_pkg::ST_DEPTH;
        end else begin
          state_next = ghbdc_pkg::ST_PUSH;
        end
      end
      ghbdc_pkg::ST_DEPTH: begin
        state_next = status.d_more ? ghbdc_pkg::ST_ADD : ghbdc_pkg::ST_LINK;
      end
      ghbdc_pkg::ST_ADD: begin
        cmd.add = 1'b1;
        state_next = ghbdc_pkg::ST_SEEN_RD;
      end
      ghbdc_pkg::ST_SEEN_RD: begin
        state_next = status.k_more ? ghbdc_pkg::ST_SEEN_CMP : ghbdc_pkg::ST_STORE;
      end
      ghbdc_pkg::ST_SEEN_CMP: begin
        if (status.seen_match) begin
          state_next = ghbdc_pkg::ST_NEXT;
        end else begin
          cmd.k_inc = 1'b1;
          state_next = ghbdc_pkg::ST_SEEN_RD;
        end
      end
      ghbdc_pkg::ST_STORE: begin
        if (status.can_store) begin
          cmd.store = 1'b1;
          state_next = ghbdc_pkg::ST_NEXT;
        end
      end
      ghbdc_pkg::ST_NEXT: begin
        cmd.depth_next = 1'b1;
        state_next = ghbdc_pkg::ST_DEPTH;
      end
      ghbdc_pkg::ST_LINK: begin
        cmd.w_inc = 1'b1;
        state_next = status.link_valid ? ghbdc_pkg::ST_LINK_CMP : ghbdc_pkg::ST_PUSH;
      end
      ghbdc_pkg::ST_LINK_CMP: begin
        if (status.link_ok) begin
          cmd.cur_follow = 1'b1;
          state_next = ghbdc_pkg::ST_CHAIN;
        end else begin
          state_next = ghbdc_pkg::ST_PUSH;
        end
      end
      ghbdc_pkg::ST_PUSH: begin
        cmd.push = 1'b1;
        state_next = ghbdc_pkg::ST_PREV;
      end
      ghbdc_pkg::ST_PREV: begin
        cmd.delta_rd_prev = 1'b1;
        state_next = status.prev_dvalid ? ghbdc_pkg::ST_PREV_KEY : ghbdc_pkg::ST_ADVANCE;
      end
      ghbdc_pkg::ST_PREV_KEY: begin
        cmd.key_from_delta = 1'b1;
        upd_phase_next = 1'b1;
        state_next = ghbdc_pkg::ST_SRCH_RD;
      end
      ghbdc_pkg::ST_ADVANCE: begin
        cmd.advance = 1'b1;
        state_next = ghbdc_pkg::ST_FLUSH;
      end
      ghbdc_pkg::ST_FLUSH: begin
        if (!status.pend_valid) begin
          state_next = ghbdc_pkg::ST_IDLE;
        end else if (status.out_free) begin
          cmd.flush = 1'b1;
          state_next = ghbdc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ghbdc_pkg::ST_IDLE;
      end
    endcase
  end

  // requests are taken only between runs
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.in_ready |-> state == ghbdc_pkg::ST_IDLE)
    else $error("request taken outside idle");

  // the update search only starts from the previous-delta read
  a_upd_entry: assert property (@(posedge clk) disable iff (rst)
    $rose(upd_phase) |-> $past(state) == ghbdc_pkg::ST_PREV_KEY)
    else $error("update phase entered out of order");

  // a run never ends with a result still pending
  a_flush_done: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |=> !status.pend_valid)
    else $error("pending result left after flush");

endmodule

`default_nettype wire

// File: rtl/core/ghbdc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module ghbdc_datapath #(
  parameter int HISTORY_ENTRIES = 256,
  parameter int INDEX_ENTRIES = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire ghbdc_pkg::cmd_t                     cmd,
  output ghbdc_pkg::status_t                       status,
  input  wire logic [ghbdc_pkg::ADDR_W-1:0]        access_address,
  input  wire logic                                write_enable,
  input  wire logic [ghbdc_pkg::REG_IDX_W-1:0]     reg_index,
  input  wire logic [ghbdc_pkg::CFG_W-1:0]         write_data,
  output logic                                     out_valid,
  output logic [ghbdc_pkg::ADDR_W-1:0]             out_address,
  output logic                                     out_last,
  input  wire logic                                out_ready
);

  localparam int HW = (HISTORY_ENTRIES > 1) ? $clog2(HISTORY_ENTRIES) : 1;
  localparam int IW = (INDEX_ENTRIES > 1) ? $clog2(INDEX_ENTRIES) : 1;
  localparam int AW = ghbdc_pkg::ADDR_W;
  localparam int GW = ghbdc_pkg::GEN_W;
  localparam int CW = ghbdc_pkg::CFG_W;
  localparam int NW = ghbdc_pkg::CNT_W;
  localparam int IDX_WORD = AW + HW + GW;
  localparam logic [HW-1:0] H_LAST = HW'(HISTORY_ENTRIES - 1);
  localparam logic [IW-1:0] I_LAST = IW'(INDEX_ENTRIES - 1);

  // configuration and control state
  logic [CW-1:0] width_cfg, depth_cfg, w_lim, d_lim, wcnt, dcnt;
  logic          prev_valid;
  logic [AW-1:0] prev_addr, addr, delta, key, cand, pend;
  logic          pend_valid;
  logic [HW-1:0] head, cur, pos, hit_ptr, prevh;
  logic [GW-1:0] gc, hit_gen;
  logic [IW-1:0] ins, scan, slot;
  logic [NW-1:0] n, k;
  logic          hist_wrapped, idx_wrapped;

  // memory ports
  logic [AW-1:0]       delta_rdata, seen_rdata;
  logic [HW-1:0]       delta_raddr, link_ptr;
  logic [HW:0]         link_rdata, link_wdata;
  logic [GW-1:0]       gen_rdata;
  logic [IDX_WORD-1:0] idx_rdata, idx_wdata;
  logic [IW-1:0]       idx_waddr;
  logic [AW-1:0]       idx_key;
  logic [HW-1:0]       idx_ptr;
  logic [GW-1:0]       idx_gen;
  logic                out_free;

  assign prevh = (head == '0) ? H_LAST : head - HW'(1);
  assign delta_raddr = cmd.delta_rd_prev ? prevh : pos;
  assign {idx_key, idx_ptr, idx_gen} = idx_rdata;
  assign idx_waddr = cmd.insert ? ins : slot;
  assign idx_wdata = {key, head, gc};
  assign link_ptr = link_rdata[HW-1:0];
  assign link_wdata = {cmd.link_set, hit_ptr};
  assign out_free = !out_valid || out_ready;

  ghbdc_ram #(.WIDTH(AW), .DEPTH(HISTORY_ENTRIES)) u_delta_ram (
    .clk(clk), .we(cmd.push), .waddr(head), .wdata(delta),
    .raddr(delta_raddr), .rdata(delta_rdata)
  );

  ghbdc_ram #(.WIDTH(GW), .DEPTH(HISTORY_ENTRIES)) u_gen_ram (
    .clk(clk), .we(cmd.push), .waddr(head), .wdata(gc),
    .raddr(hit_ptr), .rdata(gen_rdata)
  );

  // link word: valid bit over the pointer, cleared by the push
  ghbdc_ram #(.WIDTH(HW + 1), .DEPTH(HISTORY_ENTRIES)) u_link_ram (
    .clk(clk), .we(cmd.push || cmd.link_set), .waddr(head), .wdata(link_wdata),
    .raddr(cur), .rdata(link_rdata)
  );

  ghbdc_ram #(.WIDTH(IDX_WORD), .DEPTH(INDEX_ENTRIES)) u_index_ram (
    .clk(clk), .we(cmd.update || cmd.insert), .waddr(idx_waddr), .wdata(idx_wdata),
    .raddr(scan), .rdata(idx_rdata)
  );

  ghbdc_ram #(.WIDTH(AW), .DEPTH(ghbdc_pkg::MAX_RESULTS)) u_seen_ram (
    .clk(clk), .we(cmd.store), .waddr(n[ghbdc_pkg::SEEN_AW-1:0]), .wdata(cand),
    .raddr(k[ghbdc_pkg::SEEN_AW-1:0]), .rdata(seen_rdata)
  );

  // status towards the controller
  // both tables fill in order, so an entry is valid below its fill point or once wrapped
  always_comb begin
    status.prev_valid = prev_valid;
    status.scan_valid = idx_wrapped || (scan < ins);
    status.scan_last = (scan == I_LAST);
    status.key_match = (idx_key == key);
    status.live = (hit_gen == gen_rdata);
    status.w_more = (wcnt < w_lim);
    status.d_more = (dcnt < d_lim) && (hist_wrapped || (pos < head));
    status.k_more = (k < n);
    status.seen_match = (seen_rdata == cand);
    status.can_store = !pend_valid || out_free;
    status.link_valid = link_rdata[HW];
    status.link_ok = !(((link_ptr > cur) || (cur > head)) && (link_ptr < head));
    status.prev_dvalid = hist_wrapped || (head != '0);
    status.pend_valid = pend_valid;
    status.out_free = out_free;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      width_cfg <= ghbdc_pkg::WIDTH_RESET;
      depth_cfg <= ghbdc_pkg::DEPTH_RESET;
    end else if (write_enable) begin
      if (reg_index == ghbdc_pkg::REG_WIDTH) begin
        width_cfg <= write_data;
      end else if (reg_index == ghbdc_pkg::REG_DEPTH) begin
        depth_cfg <= write_data;
      end
    end
  end

  // control state with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_valid <= 1'b0;
      prev_addr <= '0;
      hist_wrapped <= 1'b0;
      idx_wrapped <= 1'b0;
      head <= '0;
      ins <= '0;
      gc <= '0;
      pend_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.take_first) begin
        prev_valid <= 1'b1;
        prev_addr <= access_address;
      end
      if (cmd.take_step) begin
        prev_addr <= access_address;
        pend_valid <= 1'b0;
      end
      if (cmd.insert) begin
        if (ins == I_LAST) begin
          ins <= '0;
          idx_wrapped <= 1'b1;
        end else begin
          ins <= ins + IW'(1);
        end
      end
      if (cmd.advance) begin
        if (head == H_LAST) begin
          head <= '0;
          gc <= gc + GW'(1);
          hist_wrapped <= 1'b1;
        end else begin
          head <= head + HW'(1);
        end
      end
      // output register
      if (cmd.flush || (cmd.store && pend_valid)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.store) begin
        pend_valid <= 1'b1;
      end
      if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take_step) begin
      addr <= access_address;
      delta <= access_address - prev_addr;
      key <= access_address - prev_addr;
      scan <= '0;
      n <= '0;
      w_lim <= (width_cfg > ghbdc_pkg::AXIS_LIMIT) ? ghbdc_pkg::AXIS_LIMIT : width_cfg;
      d_lim <= (depth_cfg > ghbdc_pkg::AXIS_LIMIT) ? ghbdc_pkg::AXIS_LIMIT : depth_cfg;
    end
    if (cmd.scan_inc) begin
      scan <= scan + IW'(1);
    end
    if (cmd.hit_latch) begin
      slot <= scan;
      hit_ptr <= idx_ptr;
      hit_gen <= idx_gen;
    end
    if (cmd.walk_start) begin
      cur <= hit_ptr;
      wcnt <= '0;
    end
    if (cmd.chain_start) begin
      pos <= cur;
      dcnt <= '0;
      cand <= addr;
    end
    if (cmd.add) begin
      cand <= cand + delta_rdata;
      k <= '0;
    end
    if (cmd.k_inc) begin
      k <= k + NW'(1);
    end
    if (cmd.store) begin
      n <= n + NW'(1);
      pend <= cand;
      if (pend_valid) begin
        out_address <= pend;
        out_last <= 1'b0;
      end
    end
    if (cmd.flush) begin
      out_address <= pend;
      out_last <= 1'b1;
    end
    if (cmd.depth_next) begin
      dcnt <= dcnt + CW'(1);
      pos <= (pos == H_LAST) ? '0 : pos + HW'(1);
    end
    if (cmd.w_inc) begin
      wcnt <= wcnt + CW'(1);
    end
    if (cmd.cur_follow) begin
      cur <= link_ptr;
    end
    if (cmd.key_from_delta) begin
      key <= delta_rdata;
      scan <= '0;
    end
  end

  // never more results per access than the seen list holds
  a_result_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.store |-> n < NW'(ghbdc_pkg::MAX_RESULTS))
    else $error("result count overflow");

  // a pending result only moves into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.flush || (cmd.store && pend_valid)) |-> out_free)
    else $error("output register overwritten");

  // the history counts as full once the head has wrapped
  a_hist_fill: assert property (@(posedge clk) disable iff (rst)
    (cmd.advance && head == H_LAST) |=> hist_wrapped)
    else $error("history wrap not recorded");

endmodule

`default_nettype wire

// File: rtl/core/ghb_delta_correlation_prefetcher_top.sv
// the first access after reset is only recorded and gives no result
// later accesses search the index for the delta, up to an empty entry or a hit; a live hit walks
// the chains, summing deltas and checking each sum against earlier results for duplicates, with
// output stalls able to hold it; a previous delta is then searched again to update the index
// accesses are taken one at a time; results leave through an output register, last flagged
// reset: synchronous, clears control state and fill marks, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module ghb_delta_correlation_prefetcher_top #(
  parameter int HISTORY_ENTRIES = 256,
  parameter int INDEX_ENTRIES = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  ghbdc_access_if.sink                         access,
  ghbdc_prefetch_if.source                     prefetch,
  input  wire logic                            write_enable,
  input  wire logic [ghbdc_pkg::REG_IDX_W-1:0] reg_index,
  input  wire logic [ghbdc_pkg::CFG_W-1:0]     write_data
);

  ghbdc_pkg::cmd_t    cmd;
  ghbdc_pkg::status_t status;

  assign access.ready = cmd.in_ready;

  // sequencer
  ghbdc_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(access.valid),
    .status(status),
    .cmd(cmd)
  );

  // history, index and result datapath
  ghbdc_datapath #(
    .HISTORY_ENTRIES(HISTORY_ENTRIES),
    .INDEX_ENTRIES(INDEX_ENTRIES)
  ) u_datapath (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .status(status),
    .access_address(access.access_address),
    .write_enable(write_enable),
    .reg_index(reg_index),
    .write_data(write_data),
    .out_valid(prefetch.valid),
    .out_address(prefetch.prefetch_address),
    .out_last(prefetch.last_of_run),
    .out_ready(prefetch.ready)
  );

endmodule

`default_nettype wire

// File: tb/tb_ghb_delta_correlation_prefetcher_top.sv
`timescale 1ns / 1ps

module tb_ghb_delta_correlation_prefetcher_top;

  localparam int HIST_N = 256;
  localparam int IDX_N = 64;
  localparam int AW = ghbdc_pkg::ADDR_W;
  localparam int CW = ghbdc_pkg::CFG_W;
  localparam int RW = ghbdc_pkg::REG_IDX_W;
  localparam logic [RW-1:0] REG_SPARE = 2'd3;
  // worst access: two full index scans plus 64 deltas each checked against 63 earlier results
  localparam int DRAIN_CYCLES = 9000;

  typedef struct {
    logic [AW-1:0] addr;
    logic          last;
  } prefetch_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic          write_enable = 1'b0;
  logic [RW-1:0] reg_index = '0;
  logic [CW-1:0] write_data = '0;

  ghbdc_access_if acc ();
  ghbdc_prefetch_if pf ();

  ghb_delta_correlation_prefetcher_top DUT (
    .clk(clk),
    .rst(rst),
    .access(acc),
    .prefetch(pf),
    .write_enable(write_enable),
    .reg_index(reg_index),
    .write_data(write_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [CW-1:0] cfg_width = ghbdc_pkg::WIDTH_RESET;
  logic [CW-1:0] cfg_depth = ghbdc_pkg::DEPTH_RESET;
  logic [AW-1:0] last_addr = '0;
  bit            last_seen = 1'b0;
  logic [AW-1:0] hist_delta [HIST_N];
  bit            hist_dv [HIST_N];
  bit [7:0]      hist_link [HIST_N];
  bit            hist_lv [HIST_N];
  bit [1:0]      hist_gen [HIST_N];
  logic [AW-1:0] idx_key [IDX_N];
  bit            idx_v [IDX_N];
  bit [7:0]      idx_ptr [IDX_N];
  bit [1:0]      idx_gen [IDX_N];
  int            hist_head = 0;
  int            ins_head = 0;
  bit [1:0]      gen_ctr = '0;

  logic [AW-1:0] pending_access [$];
  prefetch_t     expected_prefetch [$];
  int errors = 0;
  int accesses_taken = 0;
  int prefetches_seen = 0;
  int settings_used = 1;

  function automatic void add_access(input logic [AW-1:0] a);
    pending_access.insert(pending_access.size(), a);
  endfunction

  // index search: stops at the first empty slot
  function automatic int find_delta(input logic [AW-1:0] key);
    int i;
    i = 0;
    while (i < IDX_N && idx_v[i] && idx_key[i] != key) i++;
    if (i < IDX_N && idx_v[i] && idx_key[i] == key) return i;
    return IDX_N;
  endfunction

  function automatic bit slot_live(input int slot);
    return idx_gen[slot] == hist_gen[idx_ptr[slot]];
  endfunction

  function automatic void predict_access(input logic [AW-1:0] addr);
    logic [AW-1:0] dlt, cand, pd;
    logic [AW-1:0] found [$];
    int slot, cur, nxt, wl, dl, w, d, prv;
    bit ok, dup;
    prefetch_t item;
    if (!last_seen) begin
      last_addr = addr;
      last_seen = 1'b1;
      return;
    end
    dlt = addr - last_addr;
    last_addr = addr;
    wl = (cfg_width > ghbdc_pkg::AXIS_LIMIT) ? ghbdc_pkg::AXIS_LIMIT : cfg_width;
    dl = (cfg_depth > ghbdc_pkg::AXIS_LIMIT) ? ghbdc_pkg::AXIS_LIMIT : cfg_depth;
    // chain walk on a live hit
    slot = find_delta(dlt);
    if (slot < IDX_N && slot_live(slot)) begin
      cur = idx_ptr[slot];
      ok = 1'b1;
      w = 0;
      while (w < wl && ok) begin
        cand = addr;
        d = 0;
        while (d < dl && hist_dv[(cur + d) % HIST_N]) begin
          cand += hist_delta[(cur + d) % HIST_N];
          dup = 1'b0;
          foreach (found[k]) if (found[k] == cand) dup = 1'b1;
          if (!dup) found.insert(found.size(), cand);
          d++;
        end
        w++;
        if (!hist_lv[cur]) ok = 1'b0;
        else begin
          nxt = hist_link[cur];
          if ((nxt > cur || cur > hist_head) && nxt < hist_head) ok = 1'b0;
          else cur = nxt;
        end
      end
    end
    foreach (found[k]) begin
      item.addr = found[k];
      item.last = (k == found.size() - 1);
      expected_prefetch.insert(expected_prefetch.size(), item);
    end
    // push the new delta and link the previous one
    hist_delta[hist_head] = dlt;
    hist_dv[hist_head] = 1'b1;
    hist_lv[hist_head] = 1'b0;
    hist_link[hist_head] = '0;
    hist_gen[hist_head] = gen_ctr;
    prv = (hist_head > 0) ? hist_head - 1 : HIST_N - 1;
    if (hist_dv[prv]) begin
      pd = hist_delta[prv];
      slot = find_delta(pd);
      if (slot < IDX_N) begin
        if (slot_live(slot)) begin
          hist_link[hist_head] = idx_ptr[slot];
          hist_lv[hist_head] = 1'b1;
        end
        idx_ptr[slot] = hist_head;
        idx_gen[slot] = gen_ctr;
      end else begin
        idx_key[ins_head] = pd;
        idx_v[ins_head] = 1'b1;
        idx_ptr[ins_head] = hist_head;
        idx_gen[ins_head] = gen_ctr;
        ins_head = (ins_head + 1) % IDX_N;
      end
    end
    hist_head++;
    if (hist_head >= HIST_N) begin
      hist_head = 0;
      gen_ctr++;
    end
  endfunction

  // request driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  bit acc_fire;
  always @(posedge clk) begin
    acc_fire = acc.valid && acc.ready;
    if (acc_fire) begin
      predict_access(acc.access_address);
      accesses_taken++;
    end
    if (rst) begin
      acc.valid <= 1'b0;
    end else if (!acc.valid || acc_fire) begin
      if (gap_left > 0 || pending_access.size() == 0) begin
        if (gap_left > 0) gap_left--;
        acc.valid <= 1'b0;
      end else begin
        acc.valid <= 1'b1;
        acc.access_address <= pending_access.pop_front();
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 15);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  // result monitor with its own stall pattern
  bit [7:0] stall_mask = 8'hff;
  int stall_pos = 0;
  prefetch_t want;
  always @(posedge clk) begin
    if (pf.valid && pf.ready) begin
      prefetches_seen++;
      if (expected_prefetch.size() == 0) begin
        $error("unexpected prefetch_address %h last_of_run %b", pf.prefetch_address,
               pf.last_of_run);
        errors++;
      end else begin
        want = expected_prefetch.pop_front();
        if (pf.prefetch_address !== want.addr) begin
          $error("prefetch_address expected %h actual %h", want.addr, pf.prefetch_address);
          errors++;
        end
        if (pf.last_of_run !== want.last) begin
          $error("last_of_run expected %b actual %b", want.last, pf.last_of_run);
          errors++;
        end
      end
    end
    stall_pos = (stall_pos + 1) % 64;
    if (stall_pos == 0) stall_mask = ($urandom_range(0, 2) == 0) ? 8'hff : 8'($urandom);
    pf.ready <= rst ? 1'b0 : stall_mask[stall_pos % 8];
  end

  task automatic write_reg(input logic [RW-1:0] idx, input logic [CW-1:0] val);
    @(posedge clk);
    write_enable <= 1'b1;
    reg_index <= idx;
    write_data <= val;
    if (idx == ghbdc_pkg::REG_WIDTH) cfg_width = val;
    else if (idx == ghbdc_pkg::REG_DEPTH) cfg_depth = val;
    @(posedge clk);
    write_enable <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_access.size() != 0 || acc.valid) @(posedge clk);
    while (expected_prefetch.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [AW-1:0] rand_addr();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [AW-1:0] pick_delta();
    case ($urandom_range(0, 6))
      0: return 64'd64;
      1: return -64'd64;
      2: return 64'd8;
      3: return 64'd4096;
      4: return -64'd1;
      5: return 64'($urandom_range(1, 300));
      default: return rand_addr();
    endcase
  endfunction

  // mostly repeating delta patterns so chains form, with some noise
  task automatic queue_random(input int count);
    logic [AW-1:0] a;
    logic [AW-1:0] pat [4];
    int len, reps, n;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 4) == 0) begin
        add_access(rand_addr());
        n++;
      end else begin
        a = rand_addr();
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) pat[i] = pick_delta();
        reps = $urandom_range(2, 5);
        for (int r = 0; r < reps && n < count; r++)
          for (int i = 0; i < len && n < count; i++) begin
            a += pat[i];
            add_access(a);
            n++;
          end
      end
    end
  endtask

  initial begin
    acc.valid = 1'b0;
    acc.access_address = '0;
    pf.ready = 1'b0;
    foreach (hist_dv[i]) begin
      hist_dv[i] = 1'b0;
      hist_lv[i] = 1'b0;
      hist_link[i] = '0;
      hist_gen[i] = '0;
    end
    foreach (idx_v[i]) idx_v[i] = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: first access, strides, address wrap, extremes
    add_access(64'h0);
    for (int i = 1; i <= 8; i++) add_access(64'(i * 64));
    add_access(64'hffff_ffff_ffff_ffff);
    add_access(64'h0);
    add_access(64'hffff_ffff_ffff_ffff);
    add_access(64'h0);
    add_access(64'hffff_ffff_ffff_ffff);
    for (int i = 1; i <= 6; i++) add_access(64'hffff_ffff_ffff_ffff - i * 16);
    add_access(64'h8000_0000_0000_0000);
    add_access(64'h7fff_ffff_ffff_ffff);
    wait_idle();

    // random phases over several register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(ghbdc_pkg::REG_WIDTH, ghbdc_pkg::AXIS_LIMIT);
          write_reg(ghbdc_pkg::REG_DEPTH, ghbdc_pkg::AXIS_LIMIT);
        end
        1: begin
          write_reg(ghbdc_pkg::REG_WIDTH, 4'd0);
          write_reg(ghbdc_pkg::REG_DEPTH, 4'd3);
        end
        2: begin
          write_reg(ghbdc_pkg::REG_WIDTH, 4'd15);
          write_reg(ghbdc_pkg::REG_DEPTH, 4'd15);
        end
        3: begin
          write_reg(ghbdc_pkg::REG_WIDTH, 4'd1);
          write_reg(ghbdc_pkg::REG_DEPTH, 4'd0);
        end
        4: begin
          write_reg(REG_SPARE, 4'd9);
          write_reg(ghbdc_pkg::REG_WIDTH, 4'd3);
        end
        default: begin
          write_reg(ghbdc_pkg::REG_WIDTH, 4'($urandom_range(0, 15)));
          write_reg(ghbdc_pkg::REG_DEPTH, 4'($urandom_range(1, 15)));
        end
      endcase
      settings_used++;
      queue_random(48);
      wait_idle();
    end

    if (expected_prefetch.size() != 0) begin
      $error("%0d prefetch results never arrived", expected_prefetch.size());
      errors++;
    end
    $display("covered %0d accesses over %0d register settings, %0d prefetches checked",
             accesses_taken, settings_used, prefetches_seen);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // watchdog
  initial begin
    #200_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
